// ===== rtl/core/qmlp_pkg.sv =====
// Shared types, constants and helpers for the quantized two-layer MLP.
// No dependencies; used by every module under rtl/core.
package qmlp_pkg;

	// default sizes for the top-level parameters
	localparam int HIDDEN_UNITS_DEF = 16;
	localparam int CLASSES_DEF      = 3;

	// fixed field widths
	localparam int IDX_W     = 6;
	localparam int VAL_W     = 32;
	localparam int SMP_W     = 8;
	localparam int WGT_W     = 8;
	localparam int SCORE_W   = 8;
	localparam int CLS_W     = 2;
	localparam int MULT_W    = 31;
	localparam int SHIFT_W   = 6;
	localparam int ZP_W      = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 31;

	// datapath widths: accumulator covers a 32-bit bias plus up to 64 int8 products
	localparam int ACC_W  = 34;
	localparam int MAG_W  = 32;
	localparam int PROD_W = 64;
	localparam int Q_W    = 11;
	localparam int RES_W  = 13;

	localparam logic [MAG_W-1:0] MAG_MAX = 32'hFFFF_FFFF;
	localparam logic [Q_W-1:0]   Q_SAT   = 11'd1024;
	localparam logic signed [RES_W-1:0] SCORE_MAX = 13'sd127;
	localparam logic signed [RES_W-1:0] SCORE_MIN = -13'sd128;

	// register reset values
	localparam logic [MULT_W-1:0]  MULT_RST  = 31'd1073741824;
	localparam logic [SHIFT_W-1:0] SHIFT_RST = 6'd31;
	localparam logic [ZP_W-1:0]    ZP_RST    = 8'd0;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_INFER = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		TBL_HW = 2'd0,
		TBL_HB = 2'd1,
		TBL_FW = 2'd2,
		TBL_FB = 2'd3
	} tbl_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HMULT  = 3'd0,
		REG_HSHIFT = 3'd1,
		REG_HZP    = 3'd2,
		REG_FMULT  = 3'd3,
		REG_FSHIFT = 3'd4,
		REG_FZP    = 3'd5
	} reg_t;

	// controls for the shared multiply/accumulate/rescale unit
	typedef struct packed {
		logic mul;        // register a product
		logic mul_scale;  // product is magnitude times multiplier
		logic load;       // accumulator takes the bias
		logic add;        // accumulator adds the product
		logic mag;        // take magnitude of the accumulator
		logic shf;        // shift and saturate the product
	} mac_ctrl_t;

	function automatic logic signed [SCORE_W-1:0] clamp8(input logic signed [RES_W-1:0] v);
		logic signed [RES_W-1:0] t;
		t = v;
		if (v > SCORE_MAX) t = SCORE_MAX;
		if (v < SCORE_MIN) t = SCORE_MIN;
		return t[SCORE_W-1:0];
	endfunction

endpackage

// ===== rtl/core/qmlp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies beyond qmlp_pkg defaults.
module qmlp_ram #(
	parameter int WIDTH = qmlp_pkg::WGT_W,
	parameter int DEPTH = qmlp_pkg::HIDDEN_UNITS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/qmlp_mac.sv =====
// Shared arithmetic unit: one multiplier, accumulator, magnitude, shift/saturate.
// Used for both int8 products and requantization. Depends on qmlp_pkg.
module qmlp_mac (
	input  logic                                    clk,
	input  qmlp_pkg::mac_ctrl_t                     ctrl,
	input  logic signed [qmlp_pkg::SMP_W-1:0]       op_a,
	input  logic signed [qmlp_pkg::WGT_W-1:0]       op_b,
	input  logic signed [qmlp_pkg::VAL_W-1:0]       bias,
	input  logic        [qmlp_pkg::MULT_W-1:0]      mult,
	input  logic        [qmlp_pkg::SHIFT_W-1:0]     shift,
	input  logic signed [qmlp_pkg::ZP_W-1:0]        zp,
	output logic signed [qmlp_pkg::RES_W-1:0]       res
);

	logic signed [qmlp_pkg::ACC_W-1:0]  acc_q;
	logic signed [qmlp_pkg::PROD_W-1:0] prod_q;
	logic        [qmlp_pkg::MAG_W-1:0]  mag_q;
	logic                               neg_q;
	logic        [qmlp_pkg::Q_W-1:0]    q_q;

	logic signed [qmlp_pkg::MAG_W:0]    ma;
	logic signed [qmlp_pkg::MULT_W:0]   mb;
	logic signed [qmlp_pkg::MAG_W+qmlp_pkg::MULT_W+1:0] full;
	logic        [qmlp_pkg::ACC_W-1:0]  acc_abs;
	logic        [qmlp_pkg::MAG_W-1:0]  mag_d;
	logic        [qmlp_pkg::PROD_W-2:0] shifted;
	logic        [qmlp_pkg::Q_W-1:0]    q_d;
	logic signed [qmlp_pkg::RES_W-1:0]  sq;

	always_comb begin
		ma = ctrl.mul_scale ? $signed({1'b0, mag_q}) : (qmlp_pkg::MAG_W+1)'(op_a);
		mb = ctrl.mul_scale ? $signed({1'b0, mult}) : (qmlp_pkg::MULT_W+1)'(op_b);
		full = ma * mb;

		acc_abs = acc_q[qmlp_pkg::ACC_W-1] ? qmlp_pkg::ACC_W'(-acc_q) : qmlp_pkg::ACC_W'(acc_q);
		mag_d = (acc_abs > qmlp_pkg::ACC_W'(qmlp_pkg::MAG_MAX)) ? qmlp_pkg::MAG_MAX
			: acc_abs[qmlp_pkg::MAG_W-1:0];

		// requant product is non-negative, so the low 63 bits hold it
		shifted = prod_q[qmlp_pkg::PROD_W-2:0] >> shift;
		q_d = (shifted > (qmlp_pkg::PROD_W-1)'(qmlp_pkg::Q_SAT)) ? qmlp_pkg::Q_SAT
			: shifted[qmlp_pkg::Q_W-1:0];

		sq = $signed({2'b00, q_q});
		res = (neg_q ? -sq : sq) + qmlp_pkg::RES_W'(zp);
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_q <= full[qmlp_pkg::PROD_W-1:0];
		end
		if (ctrl.load) begin
			acc_q <= qmlp_pkg::ACC_W'(bias);
		end else if (ctrl.add) begin
			acc_q <= acc_q + $signed(prod_q[qmlp_pkg::ACC_W-1:0]);
		end
		if (ctrl.mag) begin
			mag_q <= mag_d;
			neg_q <= acc_q[qmlp_pkg::ACC_W-1];
		end
		if (ctrl.shf) begin
			q_q <= q_d;
		end
	end

endmodule

// ===== rtl/core/quantized_two_layer_mlp.sv =====
// Int8 two-layer MLP with argmax: sequencer, tables and one shared MAC/rescale unit.
// A load request writes its table entry when accepted. An inference runs every product and
// requantization in turn through the single multiplier, and an output stall can hold it.
// Results leave through an output register; no new request is taken during an inference.
// Reset restores register defaults; weight and bias tables are undefined until loaded.
module quantized_two_layer_mlp #(
	parameter int HIDDEN_UNITS = qmlp_pkg::HIDDEN_UNITS_DEF,
	parameter int CLASSES      = qmlp_pkg::CLASSES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [qmlp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qmlp_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 cmd,
	input  logic [1:0]                           table_select,
	input  logic [qmlp_pkg::IDX_W-1:0]           entry_index,
	input  logic signed [qmlp_pkg::VAL_W-1:0]    entry_value,
	input  logic signed [qmlp_pkg::SMP_W-1:0]    sample,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic signed [qmlp_pkg::SCORE_W-1:0]  class_score,
	output logic [qmlp_pkg::CLS_W-1:0]           class_index,
	output logic                                 is_last,
	output logic [qmlp_pkg::CLS_W-1:0]           winner
);

	localparam int HW_AW    = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
	localparam int FW_FULL  = HIDDEN_UNITS * CLASSES;
	localparam int FW_DEPTH = (FW_FULL > 2**qmlp_pkg::IDX_W) ? 2**qmlp_pkg::IDX_W : FW_FULL;
	localparam int FW_AW    = (FW_DEPTH > 1) ? $clog2(FW_DEPTH) : 1;
	localparam int CL_W     = (CLASSES > 1) ? $clog2(CLASSES) : 1;
	localparam int CNT_W    = $clog2(HIDDEN_UNITS + 1);
	localparam int FA_W     = $clog2(FW_FULL + CLASSES) + 1;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_H_RD   = 11'b000_0000_0010,
		S_H_MUL  = 11'b000_0000_0100,
		S_H_ADD  = 11'b000_0000_1000,
		S_R_MAG  = 11'b000_0001_0000,
		S_R_MUL  = 11'b000_0010_0000,
		S_R_SHF  = 11'b000_0100_0000,
		S_R_FIN  = 11'b000_1000_0000,
		S_F_BIAS = 11'b001_0000_0000,
		S_F_LOAD = 11'b010_0000_0000,
		S_F_MAC  = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [qmlp_pkg::MULT_W-1:0]      hmult_q, fmult_q;
	logic [qmlp_pkg::SHIFT_W-1:0]     hshift_q, fshift_q;
	logic signed [qmlp_pkg::ZP_W-1:0] hzp_q, fzp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hmult_q  <= qmlp_pkg::MULT_RST;
			hshift_q <= qmlp_pkg::SHIFT_RST;
			hzp_q    <= qmlp_pkg::ZP_RST;
			fmult_q  <= qmlp_pkg::MULT_RST;
			fshift_q <= qmlp_pkg::SHIFT_RST;
			fzp_q    <= qmlp_pkg::ZP_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				qmlp_pkg::REG_HMULT:  hmult_q  <= cfg_data;
				qmlp_pkg::REG_HSHIFT: hshift_q <= cfg_data[qmlp_pkg::SHIFT_W-1:0];
				qmlp_pkg::REG_HZP:    hzp_q    <= cfg_data[qmlp_pkg::ZP_W-1:0];
				qmlp_pkg::REG_FMULT:  fmult_q  <= cfg_data;
				qmlp_pkg::REG_FSHIFT: fshift_q <= cfg_data[qmlp_pkg::SHIFT_W-1:0];
				qmlp_pkg::REG_FZP:    fzp_q    <= cfg_data[qmlp_pkg::ZP_W-1:0];
				default: ;
			endcase
		end
	end

	// request side
	logic item_acc, load_acc;
	logic hw_we, hb_we, fw_we, fb_we;

	assign item_stall = (state_q != S_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign load_acc   = item_acc && (cmd == qmlp_pkg::CMD_LOAD);

	assign hw_we = load_acc && (table_select == qmlp_pkg::TBL_HW)
		&& (32'(entry_index) < HIDDEN_UNITS);
	assign hb_we = load_acc && (table_select == qmlp_pkg::TBL_HB)
		&& (32'(entry_index) < HIDDEN_UNITS);
	assign fw_we = load_acc && (table_select == qmlp_pkg::TBL_FW)
		&& (32'(entry_index) < FW_FULL);
	assign fb_we = load_acc && (table_select == qmlp_pkg::TBL_FB)
		&& (32'(entry_index) < CLASSES);

	// sequencer registers
	logic [CNT_W-1:0] cnt_q;
	logic [CL_W-1:0]  c_q;
	logic [FA_W-1:0]  fw_addr_q;
	logic             final_q;
	logic             rdv_s1, mulv_s2;
	logic signed [qmlp_pkg::SMP_W-1:0] sample_q;

	// tables
	logic [qmlp_pkg::WGT_W-1:0] hw_rdata, fw_rdata, hv_rdata;
	logic [qmlp_pkg::VAL_W-1:0] hb_rdata, fb_rdata;
	logic                       hv_we;
	logic signed [qmlp_pkg::SCORE_W-1:0] hv_wdata;

	qmlp_ram #(.WIDTH(qmlp_pkg::WGT_W), .DEPTH(HIDDEN_UNITS)) u_hw_ram (
		.clk(clk), .we(hw_we), .waddr(entry_index[HW_AW-1:0]),
		.wdata(entry_value[qmlp_pkg::WGT_W-1:0]),
		.raddr(cnt_q[HW_AW-1:0]), .rdata(hw_rdata)
	);

	qmlp_ram #(.WIDTH(qmlp_pkg::VAL_W), .DEPTH(HIDDEN_UNITS)) u_hb_ram (
		.clk(clk), .we(hb_we), .waddr(entry_index[HW_AW-1:0]), .wdata(entry_value),
		.raddr(cnt_q[HW_AW-1:0]), .rdata(hb_rdata)
	);

	qmlp_ram #(.WIDTH(qmlp_pkg::WGT_W), .DEPTH(FW_DEPTH)) u_fw_ram (
		.clk(clk), .we(fw_we), .waddr(entry_index[FW_AW-1:0]),
		.wdata(entry_value[qmlp_pkg::WGT_W-1:0]),
		.raddr(fw_addr_q[FW_AW-1:0]), .rdata(fw_rdata)
	);

	qmlp_ram #(.WIDTH(qmlp_pkg::VAL_W), .DEPTH(CLASSES)) u_fb_ram (
		.clk(clk), .we(fb_we), .waddr(entry_index[CL_W-1:0]), .wdata(entry_value),
		.raddr(c_q), .rdata(fb_rdata)
	);

	qmlp_ram #(.WIDTH(qmlp_pkg::SCORE_W), .DEPTH(HIDDEN_UNITS)) u_hv_ram (
		.clk(clk), .we(hv_we), .waddr(cnt_q[HW_AW-1:0]), .wdata(hv_wdata),
		.raddr(cnt_q[HW_AW-1:0]), .rdata(hv_rdata)
	);

	// shared unit
	qmlp_pkg::mac_ctrl_t ctrl;
	logic signed [qmlp_pkg::SMP_W-1:0]   op_a;
	logic signed [qmlp_pkg::WGT_W-1:0]   op_b;
	logic signed [qmlp_pkg::VAL_W-1:0]   bias;
	logic        [qmlp_pkg::MULT_W-1:0]  mult;
	logic        [qmlp_pkg::SHIFT_W-1:0] shift;
	logic signed [qmlp_pkg::ZP_W-1:0]    zp;
	logic signed [qmlp_pkg::RES_W-1:0]   res;

	assign op_a  = final_q ? $signed(hv_rdata) : sample_q;
	assign op_b  = final_q ? $signed(fw_rdata) : $signed(hw_rdata);
	assign bias  = final_q ? $signed(fb_rdata) : $signed(hb_rdata);
	assign mult  = final_q ? fmult_q : hmult_q;
	assign shift = final_q ? fshift_q : hshift_q;
	assign zp    = final_q ? fzp_q : hzp_q;

	qmlp_mac u_mac (
		.clk(clk), .ctrl(ctrl), .op_a(op_a), .op_b(op_b), .bias(bias),
		.mult(mult), .shift(shift), .zp(zp), .res(res)
	);

	// hidden value: ReLU at the zero point, then clamp
	logic signed [qmlp_pkg::RES_W-1:0] zp_ext, relu;

	assign zp_ext   = qmlp_pkg::RES_W'(hzp_q);
	assign relu     = (res < zp_ext) ? zp_ext : res;
	assign hv_wdata = qmlp_pkg::clamp8(relu);

	// score and running argmax
	logic signed [qmlp_pkg::SCORE_W-1:0] score, best_score_q;
	logic [CL_W-1:0]  best_idx_q, best_idx_d;
	logic             last_class, out_free, out_load;
	logic [31:0]      cidx_ext, widx_ext;

	assign score      = qmlp_pkg::clamp8(res);
	assign last_class = (c_q == CL_W'(CLASSES - 1));
	assign best_idx_d = ((c_q == '0) || (score > best_score_q)) ? c_q : best_idx_q;
	assign cidx_ext   = 32'(c_q);
	assign widx_ext   = 32'(best_idx_d);
	assign out_free   = !res_valid || !res_stall;

	always_comb begin
		ctrl     = '0;
		hv_we    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_H_MUL: begin
				ctrl.mul  = 1'b1;
				ctrl.load = 1'b1;
			end
			S_H_ADD: ctrl.add = 1'b1;
			S_R_MAG: ctrl.mag = 1'b1;
			S_R_MUL: begin
				ctrl.mul       = 1'b1;
				ctrl.mul_scale = 1'b1;
			end
			S_R_SHF: ctrl.shf = 1'b1;
			S_R_FIN: begin
				hv_we    = !final_q;
				out_load = final_q && out_free;
			end
			S_F_LOAD: ctrl.load = 1'b1;
			S_F_MAC: begin
				ctrl.mul = rdv_s1;
				ctrl.add = mulv_s2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			c_q       <= '0;
			fw_addr_q <= '0;
			final_q   <= 1'b0;
			rdv_s1    <= 1'b0;
			mulv_s2   <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			rdv_s1  <= 1'b0;
			mulv_s2 <= (state_q == S_F_MAC) && rdv_s1;
			if (out_load) begin
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_acc && (cmd == qmlp_pkg::CMD_INFER)) begin
						state_q <= S_H_RD;
						cnt_q   <= '0;
						final_q <= 1'b0;
					end
				end
				S_H_RD:  state_q <= S_H_MUL;
				S_H_MUL: state_q <= S_H_ADD;
				S_H_ADD: state_q <= S_R_MAG;
				S_R_MAG: state_q <= S_R_MUL;
				S_R_MUL: state_q <= S_R_SHF;
				S_R_SHF: state_q <= S_R_FIN;
				S_R_FIN: begin
					if (!final_q) begin
						if (cnt_q == CNT_W'(HIDDEN_UNITS - 1)) begin
							state_q <= S_F_BIAS;
							final_q <= 1'b1;
							c_q     <= '0;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_H_RD;
						end
					end else if (out_free) begin
						if (last_class) begin
							state_q <= S_IDLE;
						end else begin
							c_q     <= c_q + 1'b1;
							state_q <= S_F_BIAS;
						end
					end
				end
				S_F_BIAS: begin
					cnt_q     <= '0;
					fw_addr_q <= FA_W'(c_q);
					state_q   <= S_F_LOAD;
				end
				S_F_LOAD: begin
					// first read of the dot product goes out with the bias load
					cnt_q     <= cnt_q + 1'b1;
					fw_addr_q <= fw_addr_q + FA_W'(CLASSES);
					rdv_s1    <= 1'b1;
					state_q   <= S_F_MAC;
				end
				S_F_MAC: begin
					if (cnt_q != CNT_W'(HIDDEN_UNITS)) begin
						cnt_q     <= cnt_q + 1'b1;
						fw_addr_q <= fw_addr_q + FA_W'(CLASSES);
						rdv_s1    <= 1'b1;
					end else if (!rdv_s1 && mulv_s2) begin
						// last product is added this cycle
						state_q <= S_R_MAG;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_acc && (cmd == qmlp_pkg::CMD_INFER)) begin
			sample_q <= sample;
		end
		if (out_load) begin
			best_idx_q   <= best_idx_d;
			best_score_q <= ((c_q == '0) || (score > best_score_q)) ? score : best_score_q;
			class_score  <= score;
			class_index  <= cidx_ext[qmlp_pkg::CLS_W-1:0];
			is_last      <= last_class;
			winner       <= last_class ? widx_ext[qmlp_pkg::CLS_W-1:0] : '0;
		end
	end

endmodule
